// ----- design/edpc_pkg.sv -----
`timescale 1ns / 1ps

package edpc_pkg;

  localparam logic [7:0] ESC_BYTE     = 8'd25;
  localparam logic [7:0] ENDLINE_BYTE = 8'd30;
  localparam logic [7:0] CR_BYTE      = 8'd13;
  localparam logic [7:0] LF_BYTE      = 8'd10;

  localparam int unsigned OUT_DATA_W = 16;
  localparam int unsigned MAX_RES    = 3;
  localparam int unsigned CNT_W      = 2;

  localparam logic CFG_ABORT_AMBIG   = 1'b0;
  localparam logic CFG_ABORT_INVALID = 1'b1;

  typedef enum logic [4:0] {
    PH_IDLE        = 5'b00001,
    PH_AFTER_CR    = 5'b00010,
    PH_AFTER_ESC   = 5'b00100,
    PH_AFTER_GROUP = 5'b01000,
    PH_ABORTED     = 5'b10000
  } phase_t;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_AMBIGUOUS = 2'd1,
    ERR_INVALID   = 2'd2
  } err_t;

  typedef struct packed {
    logic       byte_valid;
    logic [7:0] out_byte;
    err_t       error_code;
    logic       stream_done;
    logic       last_of_run;
  } result_t;

  typedef struct packed {
    logic [CNT_W-1:0]     n;
    result_t [MAX_RES-1:0] res;
    phase_t               phase_nxt;
    logic                 group_we;
  } dec_t;

endpackage

// ----- design/edpc_decode.sv -----
`timescale 1ns / 1ps

module edpc_decode (
  input  logic [7:0]     in_byte,
  input  logic           in_last,
  input  edpc_pkg::phase_t phase,
  input  logic [7:0]     group,
  input  logic           abort_amb,
  input  logic           abort_inv,
  output edpc_pkg::dec_t dec
);
  import edpc_pkg::*;

  function automatic result_t mk(input logic v, input logic [7:0] b, input err_t e,
                                 input logic done);
    result_t r;
    r.byte_valid  = v;
    r.out_byte    = v ? b : 8'd0;
    r.error_code  = e;
    r.stream_done = done;
    r.last_of_run = 1'b0;
    return r;
  endfunction

  function automatic logic [7:0] pair_code(input logic [7:0] g, input logic [7:0] v);
    logic [7:0] c;
    c = 8'd0;
    case (g)
      "A": c = (v == "a") ? 8'd133 : (v == "e") ? 8'd138 : (v == "u") ? 8'd151 : 8'd0;
      "B": c = (v == "e") ? 8'd130 : (v == "E") ? 8'd144 : 8'd0;
      "C": c = (v == "a") ? 8'd131 : (v == "e") ? 8'd136 : (v == "i") ? 8'd140 :
               (v == "o") ? 8'd147 : (v == "u") ? 8'd150 : 8'd0;
      "H": c = (v == "e") ? 8'd137 : (v == "i") ? 8'd139 : (v == "u") ? 8'd129 : 8'd0;
      "K": c = (v == "c") ? 8'd135 : (v == "C") ? 8'd128 : 8'd0;
      default: c = 8'd0;
    endcase
    return c;
  endfunction

  logic       is_group;
  logic [7:0] code;
  err_t       idle_err;
  logic [1:0] idle_n;
  result_t    idle_r0;
  result_t    idle_r1;
  phase_t     idle_ph;

  assign is_group = (in_byte == "A") || (in_byte == "B") || (in_byte == "C") ||
                    (in_byte == "H") || (in_byte == "K");
  assign code     = pair_code(group, in_byte);
  assign idle_err = (phase == PH_AFTER_CR && in_byte == LF_BYTE) ? ERR_AMBIGUOUS : ERR_NONE;

  // plain byte handling as in the idle phase
  always_comb begin
    idle_r0 = mk(1'b1, in_byte, idle_err, 1'b0);
    idle_r1 = mk(1'b1, LF_BYTE, idle_err, 1'b0);
    idle_n  = 2'd1;
    idle_ph = PH_IDLE;
    if (in_byte == ENDLINE_BYTE) begin
      idle_r0 = mk(1'b1, CR_BYTE, idle_err, 1'b0);
      idle_n  = 2'd2;
    end else if (in_byte == CR_BYTE) begin
      idle_n  = 2'd0;
      idle_ph = PH_AFTER_CR;
    end else if (in_byte == ESC_BYTE) begin
      idle_n  = 2'd0;
      idle_ph = PH_AFTER_ESC;
    end
  end

  always_comb begin
    dec.n         = 2'd0;
    dec.res[0]    = mk(1'b0, 8'd0, ERR_NONE, 1'b0);
    dec.res[1]    = mk(1'b0, 8'd0, ERR_NONE, 1'b0);
    dec.res[2]    = mk(1'b0, 8'd0, ERR_NONE, 1'b0);
    dec.phase_nxt = phase;
    dec.group_we  = 1'b0;
    if (in_last) begin
      dec.phase_nxt = PH_IDLE;
      dec.n         = 2'd1;
      unique case (phase)
        PH_AFTER_CR: dec.res[0] = mk(1'b1, CR_BYTE, ERR_NONE, 1'b1);
        PH_AFTER_ESC: begin
          dec.res[0] = abort_inv ? mk(1'b0, 8'd0, ERR_INVALID, 1'b1)
                                 : mk(1'b1, ESC_BYTE, ERR_INVALID, 1'b1);
        end
        PH_AFTER_GROUP: begin
          if (abort_inv) begin
            dec.res[0] = mk(1'b0, 8'd0, ERR_INVALID, 1'b1);
          end else begin
            dec.res[0] = mk(1'b1, ESC_BYTE, ERR_INVALID, 1'b1);
            dec.res[1] = mk(1'b1, group, ERR_INVALID, 1'b1);
            dec.n      = 2'd2;
          end
        end
        default: dec.res[0] = mk(1'b0, 8'd0, ERR_NONE, 1'b1);
      endcase
    end else begin
      unique case (phase)
        PH_ABORTED: dec.phase_nxt = PH_ABORTED;
        PH_AFTER_CR: begin
          if (in_byte == LF_BYTE && abort_amb) begin
            dec.res[0]    = mk(1'b0, 8'd0, ERR_AMBIGUOUS, 1'b1);
            dec.n         = 2'd1;
            dec.phase_nxt = PH_ABORTED;
          end else begin
            dec.res[0]    = mk(1'b1, CR_BYTE, idle_err, 1'b0);
            dec.res[1]    = idle_r0;
            dec.res[2]    = idle_r1;
            dec.n         = idle_n + 2'd1;
            dec.phase_nxt = idle_ph;
          end
        end
        PH_AFTER_ESC: begin
          if (is_group) begin
            dec.group_we  = 1'b1;
            dec.phase_nxt = PH_AFTER_GROUP;
          end else if (abort_inv) begin
            dec.res[0]    = mk(1'b0, 8'd0, ERR_INVALID, 1'b1);
            dec.n         = 2'd1;
            dec.phase_nxt = PH_ABORTED;
          end else begin
            dec.res[0]    = mk(1'b1, ESC_BYTE, ERR_INVALID, 1'b0);
            dec.res[1]    = mk(1'b1, in_byte, ERR_INVALID, 1'b0);
            dec.n         = 2'd2;
            dec.phase_nxt = PH_IDLE;
          end
        end
        PH_AFTER_GROUP: begin
          if (code != 8'd0) begin
            dec.res[0]    = mk(1'b1, code, ERR_NONE, 1'b0);
            dec.n         = 2'd1;
            dec.phase_nxt = PH_IDLE;
          end else if (abort_inv) begin
            dec.res[0]    = mk(1'b0, 8'd0, ERR_INVALID, 1'b1);
            dec.n         = 2'd1;
            dec.phase_nxt = PH_ABORTED;
          end else begin
            dec.res[0]    = mk(1'b1, ESC_BYTE, ERR_INVALID, 1'b0);
            dec.res[1]    = mk(1'b1, group, ERR_INVALID, 1'b0);
            dec.res[2]    = mk(1'b1, in_byte, ERR_INVALID, 1'b0);
            dec.n         = 2'd3;
            dec.phase_nxt = PH_IDLE;
          end
        end
        default: begin
          dec.res[0]    = idle_r0;
          dec.res[1]    = idle_r1;
          dec.n         = idle_n;
          dec.phase_nxt = idle_ph;
        end
      endcase
    end
    case (dec.n)
      2'd1: dec.res[0].last_of_run = 1'b1;
      2'd2: dec.res[1].last_of_run = 1'b1;
      2'd3: dec.res[2].last_of_run = 1'b1;
      default: ;
    endcase
  end

endmodule

// ----- design/edpc_out_buf.sv -----
`timescale 1ns / 1ps

module edpc_out_buf (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  load,
  input  edpc_pkg::dec_t        dec,
  output logic                  buf_free,
  output logic                  out_valid,
  input  logic                  out_ready,
  output edpc_pkg::result_t     head
);
  import edpc_pkg::*;

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  result_t          res_r [MAX_RES];
  logic             pop;

  assign out_valid = (count_r != '0);
  assign pop       = out_valid && out_ready;
  assign buf_free  = (count_r == '0) || (count_r == CNT_W'(1) && out_ready);
  assign head      = res_r[0];

  always_comb begin
    count_nxt = count_r;
    if (load) begin
      count_nxt = dec.n;
    end else if (pop) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r[0] <= dec.res[0];
      res_r[1] <= dec.res[1];
      res_r[2] <= dec.res[2];
    end else if (pop) begin
      res_r[0] <= res_r[1];
      res_r[1] <= res_r[2];
    end
  end

  a_load_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> (count_r == '0) || (count_r == CNT_W'(1) && pop))
    else $error("result buffer overwritten");

  a_load_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> out_valid)
    else $error("load left buffer empty");

  a_last_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && count_r == CNT_W'(1)) |-> head.last_of_run)
    else $error("final buffered result lacks last flag");

endmodule

// ----- design/escape_diacritic_to_pc_decoder_unit.sv -----
`timescale 1ns / 1ps

// channel  dir  handshake              payload
// in_      in   in_tvalid/in_tready    in_tdata[7:0] in_byte, in_tlast stream_end
// out_     out  out_tvalid/out_tready  out_tdata byte/err/done, out_tuser byte_valid,
//                                      out_tlast last_of_run
// cfg_     in   cfg_valid/cfg_ready    cfg_index, cfg_data
//
// one input request per cycle when each causes at most one result and out_tready stays high
// an input causing n results (n up to 3) presents them on the output one after another
// decode sits between the input register and a three-entry result shifter
// synchronous active-low reset returns phase to idle and clears config
// input stalls only while the result shifter still holds earlier results
module escape_diacritic_to_pc_decoder_unit (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [7:0]                in_tdata,   // [7:0] in_byte
  input  logic                      in_tlast,   // stream_end
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [edpc_pkg::OUT_DATA_W-1:0] out_tdata, // [7:0] out_byte, [9:8] error_code,
                                                     // [10] stream_done
  output logic                      out_tuser,  // byte_valid
  output logic                      out_tlast,  // last_of_run
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic                      cfg_index,
  input  logic                      cfg_data
);
  import edpc_pkg::*;

  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic       in_last_r;
  phase_t     phase_r;
  logic [7:0] group_r;
  logic       abort_amb_r;
  logic       abort_inv_r;

  dec_t       dec;
  logic       buf_free;
  logic       fire;
  logic       load;
  result_t    head;

  edpc_decode u_decode (
    .in_byte   (in_byte_r),
    .in_last   (in_last_r),
    .phase     (phase_r),
    .group     (group_r),
    .abort_amb (abort_amb_r),
    .abort_inv (abort_inv_r),
    .dec       (dec)
  );

  assign fire      = in_valid_r && ((dec.n == '0) || buf_free);
  assign load      = fire && (dec.n != '0);
  assign in_tready = !in_valid_r || fire;
  assign cfg_ready = 1'b1;

  edpc_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .dec       (dec),
    .buf_free  (buf_free),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .head      (head)
  );

  assign out_tdata = {5'd0, head.stream_done, head.error_code, head.out_byte};
  assign out_tuser = head.byte_valid;
  assign out_tlast = head.last_of_run;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      group_r <= 8'd0;
    end else if (fire) begin
      phase_r <= dec.phase_nxt;
      if (dec.group_we) begin
        group_r <= in_byte_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      abort_amb_r <= 1'b0;
      abort_inv_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ABORT_AMBIG:   abort_amb_r <= cfg_data;
        CFG_ABORT_INVALID: abort_inv_r <= cfg_data;
        default: ;
      endcase
    end
  end

  a_aborted_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && phase_r == PH_ABORTED && !in_last_r) |-> (dec.n == '0))
    else $error("aborted stream produced a result");

  a_end_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && in_last_r) |=> (phase_r == PH_IDLE))
    else $error("end of stream did not return to idle");

  a_end_single_or_flush: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && in_last_r) |-> (dec.n != '0) && dec.res[0].stream_done)
    else $error("end of stream without done result");

endmodule
